/* rtl/lbo_pkg.sv */
package lbo_pkg;

  localparam int COLOR_BITS = 24;
  localparam int IN_LABEL_BITS = 8;
  localparam int FRAME_W_BITS = 12;
  localparam int FRAME_H_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 24;
  localparam int JOB_DEPTH = 4;
  localparam int JOB_PTR_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_OUTLINE_COLOR = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [IN_LABEL_BITS-1:0] pixel_label;
    logic [COLOR_BITS-1:0]    pixel_color;
  } pixel_in_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] out_color;
    logic                  last_of_run;
    logic                  end_of_frame;
  } pixel_out_t;

  typedef struct packed {
    logic [FRAME_W_BITS-1:0] frame_width;
    logic [FRAME_H_BITS-1:0] frame_height;
    logic [COLOR_BITS-1:0]   outline_color;
  } cfg_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] above_color;
    logic [COLOR_BITS-1:0] cur_color;
    logic                  edge_hit;
    logic                  has_above;
    logic                  last_col;
    logic                  last_row;
  } job_t;

endpackage

/* rtl/lbo_front.sv */
module lbo_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int LABEL_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lbo_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  lbo_pkg::pixel_in_t in_pixel,
  output logic              job_valid,
  input  logic              job_stall,
  output lbo_pkg::job_t     job
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > lbo_pkg::FRAME_W_BITS) ? CW + 1 : lbo_pkg::FRAME_W_BITS;
  localparam int EW = LABEL_BITS + lbo_pkg::COLOR_BITS;

  logic [CW-1:0]                     col_cnt_r, col_cnt_nxt;
  logic [lbo_pkg::FRAME_H_BITS-1:0] row_cnt_r, row_cnt_nxt;
  logic [EW-1:0]                     line_mem [MAX_WIDTH];
  logic [EW-1:0]                     above_q;
  logic [LABEL_BITS-1:0]             right_q;

  logic                              s1_valid_r, s1_valid_nxt;
  logic [LABEL_BITS-1:0]             lab_r;
  logic [lbo_pkg::COLOR_BITS-1:0]    color_r;
  logic                              last_col_r, last_row_r, has_above_r;

  logic                              accept;
  logic [LABEL_BITS-1:0]             lab_in;
  logic [WW-1:0]                     fw_ext, wm1, x_ext;
  logic [lbo_pkg::FRAME_H_BITS-1:0] hm1;
  logic                              last_col, last_row, has_above;
  logic [CW-1:0]                     x_p1;
  logic [LABEL_BITS-1:0]             above_lab, right_lab;

  assign in_stall = s1_valid_r && job_stall;
  assign accept   = in_valid && !in_stall;
  assign lab_in   = LABEL_BITS'(in_pixel.pixel_label);

  always_comb begin
    fw_ext = WW'(cfg.frame_width);
    priority if (fw_ext == '0) begin
      wm1 = '0;
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      wm1 = WW'(MAX_WIDTH - 1);
    end else begin
      wm1 = fw_ext - WW'(1);
    end
    hm1       = (cfg.frame_height == '0) ? '0 : cfg.frame_height - 16'd1;
    x_ext     = WW'(col_cnt_r);
    last_col  = x_ext >= wm1;
    last_row  = row_cnt_r >= hm1;
    has_above = row_cnt_r != '0;
    x_p1      = col_cnt_r + CW'(1);
  end

  // raster counters
  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (accept) begin
      if (last_col) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = last_row ? '0 : row_cnt_r + 16'd1;
      end else begin
        col_cnt_nxt = x_p1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // line store: reads see the previous row before this item overwrites its column
  always_ff @(posedge clk) begin
    if (accept) begin
      above_q             <= line_mem[col_cnt_r];
      right_q             <= line_mem[x_p1][EW-1 -: LABEL_BITS];
      line_mem[col_cnt_r] <= {lab_in, in_pixel.pixel_color};
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = has_above || last_row;
    end else if (!job_stall) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lab_r       <= lab_in;
      color_r     <= in_pixel.pixel_color;
      last_col_r  <= last_col;
      last_row_r  <= last_row;
      has_above_r <= has_above;
    end
  end

  assign above_lab = above_q[EW-1 -: LABEL_BITS];
  assign right_lab = right_q;

  always_comb begin
    job.above_color = above_q[lbo_pkg::COLOR_BITS-1:0];
    job.cur_color   = color_r;
    job.edge_hit    = !last_col_r && ((above_lab != lab_r) || (right_lab != above_lab));
    job.has_above   = has_above_r;
    job.last_col    = last_col_r;
    job.last_row    = last_row_r;
  end

  assign job_valid = s1_valid_r;

endmodule

/* rtl/lbo_job_fifo.sv */
module lbo_job_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_stall,
  input  lbo_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output lbo_pkg::job_t pop_job
);

  lbo_pkg::job_t                     slot_r [lbo_pkg::JOB_DEPTH];
  logic [lbo_pkg::JOB_PTR_BITS-1:0]  wr_ptr_r, rd_ptr_r;
  logic [lbo_pkg::JOB_PTR_BITS:0]    count_r, count_nxt;
  logic                              do_push, do_pop;

  assign push_stall = count_r == (lbo_pkg::JOB_PTR_BITS + 1)'(lbo_pkg::JOB_DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_job    = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + (lbo_pkg::JOB_PTR_BITS + 1)'(1);
      2'b01:   count_nxt = count_r - (lbo_pkg::JOB_PTR_BITS + 1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + (lbo_pkg::JOB_PTR_BITS)'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + (lbo_pkg::JOB_PTR_BITS)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* rtl/lbo_emit.sv */
module lbo_emit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [lbo_pkg::COLOR_BITS-1:0] outline_color,
  input  logic                           job_valid,
  output logic                           job_ready,
  input  lbo_pkg::job_t                  job,
  output logic                           out_valid,
  input  logic                           out_stall,
  output lbo_pkg::pixel_out_t            out_pixel
);

  logic                out_valid_r, out_valid_nxt;
  lbo_pkg::pixel_out_t out_pixel_r, out_pixel_nxt;
  logic                second_r, second_nxt;
  logic                load, two_res, emit_above;

  assign load       = !out_valid_r || !out_stall;
  assign two_res    = job.has_above && job.last_row;
  // the pixel above goes out first; the own pixel follows on the last row
  assign emit_above = job.has_above && !second_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pixel_nxt = out_pixel_r;
    second_nxt    = second_r;
    job_ready     = 1'b0;
    if (load) begin
      out_valid_nxt = job_valid;
      if (job_valid) begin
        if (emit_above) begin
          out_pixel_nxt.out_color    = job.edge_hit ? outline_color : job.above_color;
          out_pixel_nxt.last_of_run  = !job.last_row;
          out_pixel_nxt.end_of_frame = 1'b0;
        end else begin
          out_pixel_nxt.out_color    = job.cur_color;
          out_pixel_nxt.last_of_run  = 1'b1;
          out_pixel_nxt.end_of_frame = job.last_col;
        end
        if (two_res && !second_r) begin
          second_nxt = 1'b1;
        end else begin
          second_nxt = 1'b0;
          job_ready  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      second_r    <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_r <= out_pixel_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

endmodule

/* rtl/label_boundary_outline.sv */
// an item's result passes the front register, the job queue and the output register
// throughput: 1 item per cycle unless stalled; last-row items below row 0 give two results
// a stall on the result side is absorbed by a 4-entry job queue before input stalls
// reset: counters at frame start, queue and output empty, size 640 x 480, outline 0
// reset does not clear the line store; each column is written in the first row
module label_boundary_outline #(
  parameter int MAX_WIDTH  = 2048,
  parameter int LABEL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wen,
  input  logic [lbo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lbo_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lbo_pkg::pixel_in_t                  in_pixel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lbo_pkg::pixel_out_t                 out_pixel
);

  lbo_pkg::cfg_t cfg_r;
  lbo_pkg::job_t front_job, fifo_job;
  logic          front_valid, front_stall;
  logic          fifo_valid, fifo_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width   <= 12'd640;
      cfg_r.frame_height  <= 16'd480;
      cfg_r.outline_color <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        lbo_pkg::CFG_FRAME_WIDTH: begin
          cfg_r.frame_width <= cfg_wdata[lbo_pkg::FRAME_W_BITS-1:0];
        end
        lbo_pkg::CFG_FRAME_HEIGHT: begin
          cfg_r.frame_height <= cfg_wdata[lbo_pkg::FRAME_H_BITS-1:0];
        end
        lbo_pkg::CFG_OUTLINE_COLOR: begin
          cfg_r.outline_color <= cfg_wdata[lbo_pkg::COLOR_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  lbo_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .LABEL_BITS (LABEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pixel  (in_pixel),
    .job_valid (front_valid),
    .job_stall (front_stall),
    .job       (front_job)
  );

  lbo_job_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_stall (front_stall),
    .push_job   (front_job),
    .pop_valid  (fifo_valid),
    .pop_ready  (fifo_ready),
    .pop_job    (fifo_job)
  );

  lbo_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .outline_color (cfg_r.outline_color),
    .job_valid     (fifo_valid),
    .job_ready     (fifo_ready),
    .job           (fifo_job),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel     (out_pixel)
  );

endmodule
